// ===== rtl/vector3_arith_unit_defines.svh =====
// Assertion macros shared by the vector arithmetic unit
`ifndef VECTOR3_ARITH_UNIT_DEFINES_SVH
`define VECTOR3_ARITH_UNIT_DEFINES_SVH

// pre implies post, checked at every clk edge outside reset
`define VAU_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// cond never holds, checked at every clk edge outside reset
`define VAU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/vau_pkg.sv =====
// Types, command codes and saturation helper for the vector arithmetic unit
`timescale 1ns / 1ps
package vau_pkg;

    localparam int W             = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PW            = 2 * W;
    localparam int SAT_W         = 2 * W + 2;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_SCALE = 4'd2;
    localparam logic [3:0] CMD_DIV   = 4'd3;
    localparam logic [3:0] CMD_DOT   = 4'd4;
    localparam logic [3:0] CMD_CROSS = 4'd5;
    localparam logic [3:0] CMD_LEN   = 4'd6;
    localparam logic [3:0] CMD_NORM  = 4'd7;
    localparam logic [3:0] CMD_NEG   = 4'd8;

    typedef struct packed {
        logic [3:0]            command;
        logic signed [W-1:0]   ax;
        logic signed [W-1:0]   ay;
        logic signed [W-1:0]   az;
        logic signed [W-1:0]   bx;
        logic signed [W-1:0]   by_comp;
        logic signed [W-1:0]   bz;
        logic signed [W-1:0]   scalar_in;
    } in_item_t;

    typedef struct packed {
        logic signed [W-1:0]   rx;
        logic signed [W-1:0]   ry;
        logic signed [W-1:0]   rz;
        logic signed [W-1:0]   scalar_out;
        logic                  overflow;
        logic                  div_zero;
    } out_item_t;

    // item context carried down the cell chain
    typedef struct packed {
        logic [3:0]            cmd;
        logic [2:0]            a_neg;
        logic [2:0][W-1:0]     a_mag;
        logic                  s_neg;
        logic [W-1:0]          s_mag;
        logic [2:0][W-1:0]     r_word;
        logic [W-1:0]          so_word;
        logic                  ovf;
    } ctx_t;

    // square root cell payload
    typedef struct packed {
        ctx_t                  ctx;
        logic [PW-1:0]         n;
        logic [W+1:0]          rem;
        logic [W-1:0]          root;
    } sq_t;

    typedef struct packed {
        logic                  ovf;
        logic [W-1:0]          word;
    } sat_t;

    // sign and magnitude to a saturated two's complement word
    function automatic sat_t sat_word(input logic neg, input logic [SAT_W-1:0] mag);
        sat_t              r;
        logic [SAT_W-1:0]  lim;
        logic [W-1:0]      m;
        lim    = {{(SAT_W-W){1'b0}}, neg, {(W-1){~neg}}};
        r.ovf  = mag > lim;
        m      = r.ovf ? lim[W-1:0] : mag[W-1:0];
        r.word = neg ? (~m + 1'b1) : m;
        return r;
    endfunction

endpackage

// ===== rtl/vau_front.sv =====
// Front pipeline: operand capture, products, sums and saturation of direct results
`timescale 1ns / 1ps
module vau_front
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_item_t  item,
    output logic      out_valid,
    output sq_t       out_sq
);

    // stage 1: input capture
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_item_reg <= item;
        end
    end

    logic signed [W-1:0] a [3];
    logic signed [W-1:0] b [3];
    logic signed [W-1:0] s;
    logic signed [W-1:0] mul_a [6];
    logic signed [W-1:0] mul_b [6];
    logic signed [PW-1:0] p_next [6];
    logic signed [W:0]    lin_next [3];
    logic [2:0]           a_neg_next;
    logic [2:0][W-1:0]    a_mag_next;
    logic [W-1:0]         s_mag_next;

    assign a[0] = s1_item_reg.ax;
    assign a[1] = s1_item_reg.ay;
    assign a[2] = s1_item_reg.az;
    assign b[0] = s1_item_reg.bx;
    assign b[1] = s1_item_reg.by_comp;
    assign b[2] = s1_item_reg.bz;
    assign s    = s1_item_reg.scalar_in;

    // operand selection for the six multipliers
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_neg_next[i] = a[i][W-1];
            a_mag_next[i] = a[i][W-1] ? (~a[i] + 1'b1) : a[i];
            mul_a[i]      = a[i];
            mul_b[i]      = b[i];
            mul_a[i+3]    = a[(i+2)%3];
            mul_b[i+3]    = b[(i+1)%3];
            lin_next[i]   = '0;
        end
        s_mag_next = s[W-1] ? (~s + 1'b1) : s;
        unique case (s1_item_reg.command) inside
            CMD_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_b[i] = s;
                end
            end
            CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = a[(i+1)%3];
                    mul_b[i] = b[(i+2)%3];
                end
            end
            CMD_LEN, CMD_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_b[i] = a[i];
                end
            end
            CMD_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lin_next[i] = (W+1)'(a[i]) + (W+1)'(b[i]);
                end
            end
            CMD_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lin_next[i] = (W+1)'(a[i]) - (W+1)'(b[i]);
                end
            end
            CMD_NEG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lin_next[i] = -(W+1)'(a[i]);
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            p_next[i] = PW'(mul_a[i]) * PW'(mul_b[i]);
        end
    end

    // stage 2: products
    logic                 s2_valid_reg;
    logic [3:0]           s2_cmd_reg;
    logic signed [PW-1:0] s2_p_reg [6];
    logic signed [W:0]    s2_lin_reg [3];
    logic [2:0]           s2_a_neg_reg;
    logic [2:0][W-1:0]    s2_a_mag_reg;
    logic                 s2_s_neg_reg;
    logic [W-1:0]         s2_s_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg   <= s1_item_reg.command;
        s2_p_reg     <= p_next;
        s2_lin_reg   <= lin_next;
        s2_a_neg_reg <= a_neg_next;
        s2_a_mag_reg <= a_mag_next;
        s2_s_neg_reg <= s[W-1];
        s2_s_mag_reg <= s_mag_next;
    end

    // sums of products and saturation of the linear results
    logic signed [SAT_W-1:0] sum_next [3];
    logic [W:0]              lmag;
    sat_t                    lsat_next [3];

    always_comb
    begin
        lmag = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]  = SAT_W'(s2_p_reg[i]);
            lmag         = s2_lin_reg[i][W] ? (~s2_lin_reg[i] + 1'b1) : s2_lin_reg[i];
            lsat_next[i] = sat_word(s2_lin_reg[i][W], SAT_W'(lmag));
        end
        unique case (s2_cmd_reg) inside
            CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sum_next[i] = SAT_W'(s2_p_reg[i]) - SAT_W'(s2_p_reg[i+3]);
                end
            end
            CMD_DOT, CMD_LEN, CMD_NORM:
            begin
                sum_next[0] = SAT_W'(s2_p_reg[0]) + SAT_W'(s2_p_reg[1])
                            + SAT_W'(s2_p_reg[2]);
            end
            default:
            begin
            end
        endcase
    end

    // stage 3: sums
    logic                    s3_valid_reg;
    logic [3:0]              s3_cmd_reg;
    logic signed [SAT_W-1:0] s3_sum_reg [3];
    sat_t                    s3_lsat_reg [3];
    logic [2:0]              s3_a_neg_reg;
    logic [2:0][W-1:0]       s3_a_mag_reg;
    logic                    s3_s_neg_reg;
    logic [W-1:0]            s3_s_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_cmd_reg   <= s2_cmd_reg;
        s3_sum_reg   <= sum_next;
        s3_lsat_reg  <= lsat_next;
        s3_a_neg_reg <= s2_a_neg_reg;
        s3_a_mag_reg <= s2_a_mag_reg;
        s3_s_neg_reg <= s2_s_neg_reg;
        s3_s_mag_reg <= s2_s_mag_reg;
    end

    // fraction shift (toward zero) and saturation of product results
    logic [SAT_W-1:0] pmag;
    sat_t             psat [3];
    sq_t              sq_next;

    always_comb
    begin
        pmag = '0;
        for (int i = 0; i < 3; i++)
        begin
            pmag    = s3_sum_reg[i][SAT_W-1] ? (~s3_sum_reg[i] + 1'b1) : s3_sum_reg[i];
            psat[i] = sat_word(s3_sum_reg[i][SAT_W-1], pmag >> FRAC_BITS);
        end
        sq_next            = '0;
        sq_next.n          = s3_sum_reg[0][PW-1:0];
        sq_next.ctx.cmd    = s3_cmd_reg;
        sq_next.ctx.a_neg  = s3_a_neg_reg;
        sq_next.ctx.a_mag  = s3_a_mag_reg;
        sq_next.ctx.s_neg  = s3_s_neg_reg;
        sq_next.ctx.s_mag  = s3_s_mag_reg;
        unique case (s3_cmd_reg) inside
            CMD_ADD, CMD_SUB, CMD_NEG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_next.ctx.r_word[i] = s3_lsat_reg[i].word;
                end
                sq_next.ctx.ovf = s3_lsat_reg[0].ovf | s3_lsat_reg[1].ovf
                                | s3_lsat_reg[2].ovf;
            end
            CMD_SCALE, CMD_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_next.ctx.r_word[i] = psat[i].word;
                end
                sq_next.ctx.ovf = psat[0].ovf | psat[1].ovf | psat[2].ovf;
            end
            CMD_DOT:
            begin
                sq_next.ctx.so_word = psat[0].word;
                sq_next.ctx.ovf     = psat[0].ovf;
            end
            default:
            begin
            end
        endcase
    end

    // stage 4: hand off to the cell chain
    logic s4_valid_reg;
    sq_t  s4_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_sq_reg <= sq_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_sq    = s4_sq_reg;

endmodule

// ===== rtl/vau_sqrt_cell.sv =====
// One square root cell: settles one root bit per item per cycle
`timescale 1ns / 1ps
module vau_sqrt_cell
    import vau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  sq_t   in_sq,
    output logic  out_valid,
    output sq_t   out_sq
);

    logic [W+3:0] sh;
    logic [W+3:0] trial;
    sq_t          sq_next;
    logic         valid_reg;
    sq_t          sq_reg;

    // restoring step on the next two radicand bits
    always_comb
    begin
        sh          = {in_sq.rem, in_sq.n[PW-1 -: 2]};
        trial       = {2'b00, in_sq.root, 2'b01};
        sq_next     = in_sq;
        sq_next.n   = {in_sq.n[PW-3:0], 2'b00};
        if (sh >= trial)
        begin
            sq_next.rem  = (W+2)'(sh - trial);
            sq_next.root = {in_sq.root[W-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = sh[W+1:0];
            sq_next.root = {in_sq.root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;

endmodule

// ===== rtl/vau_div_cell.sv =====
// One divider cell: settles one quotient bit in each of three lanes per cycle
`timescale 1ns / 1ps
module vau_div_cell
    import vau_pkg::*;
#(
    parameter int QW = W + FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ctx_t               in_ctx,
    input  logic [W-1:0]       in_div,
    input  logic [2:0][QW-1:0] in_num,
    input  logic [2:0][W-1:0]  in_rem,
    input  logic [2:0][QW-1:0] in_quo,
    output logic               out_valid,
    output ctx_t               out_ctx,
    output logic [W-1:0]       out_div,
    output logic [2:0][QW-1:0] out_num,
    output logic [2:0][W-1:0]  out_rem,
    output logic [2:0][QW-1:0] out_quo
);

    logic [W:0]         rsh;
    logic               qbit;
    logic [2:0][W-1:0]  rem_next;
    logic [2:0][QW-1:0] num_next;
    logic [2:0][QW-1:0] quo_next;

    logic               valid_reg;
    ctx_t               ctx_reg;
    logic [W-1:0]       div_reg;
    logic [2:0][QW-1:0] num_reg;
    logic [2:0][W-1:0]  rem_reg;
    logic [2:0][QW-1:0] quo_reg;

    // restoring step per lane
    always_comb
    begin
        rsh  = '0;
        qbit = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rsh  = {in_rem[i], in_num[i][QW-1]};
            qbit = rsh >= {1'b0, in_div};
            rem_next[i] = qbit ? W'(rsh - {1'b0, in_div}) : rsh[W-1:0];
            num_next[i] = {in_num[i][QW-2:0], 1'b0};
            quo_next[i] = {in_quo[i][QW-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg <= in_ctx;
        div_reg <= in_div;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign out_valid = valid_reg;
    assign out_ctx   = ctx_reg;
    assign out_div   = div_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

// ===== rtl/vector3_arith_unit.sv =====
// Top level of the three-component fixed-point vector arithmetic unit
`timescale 1ns / 1ps
`include "vector3_arith_unit_defines.svh"
// Fully pipelined: busy stays low and a new item is taken on every cycle that
// start is high. Each item's result appears on result with done high for one
// cycle. Each item runs through the front pipeline, then the cell chains, then
// the output register (Q16.16 by default). The chains hold one square
// root cell per root bit (W cells) and one divider cell per quotient
// bit (W + FRAC_BITS cells), every item passing through both. The
// receiver cannot stall; done must be consumed in the cycle it is shown.
module vector3_arith_unit
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   item,
    output logic       done,
    output out_item_t  result
);

    localparam int QW  = W + FRAC_BITS;
    localparam int LAT = 4 + W + QW + 1;

    assign busy = 1'b0;

    // front pipeline
    logic sq_valid [W+1];
    sq_t  sq_chain [W+1];

    vau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .item      (item),
        .out_valid (sq_valid[0]),
        .out_sq    (sq_chain[0])
    );

    // square root chain
    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        vau_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_sq     (sq_chain[k]),
            .out_valid (sq_valid[k+1]),
            .out_sq    (sq_chain[k+1])
        );
    end

    // divider seeds: quotient against |scalar| or the length
    logic               dv_valid [QW+1];
    ctx_t               dv_ctx   [QW+1];
    logic [W-1:0]       dv_div   [QW+1];
    logic [2:0][QW-1:0] dv_num   [QW+1];
    logic [2:0][W-1:0]  dv_rem   [QW+1];
    logic [2:0][QW-1:0] dv_quo   [QW+1];

    assign dv_valid[0] = sq_valid[W];
    assign dv_ctx[0]   = sq_chain[W].ctx;
    assign dv_div[0]   = (sq_chain[W].ctx.cmd == CMD_DIV) ? sq_chain[W].ctx.s_mag
                                                          : sq_chain[W].root;
    assign dv_rem[0]   = '0;
    assign dv_quo[0]   = '0;

    for (genvar i = 0; i < 3; i++)
    begin : g_seed
        assign dv_num[0][i] = {sq_chain[W].ctx.a_mag[i], {FRAC_BITS{1'b0}}};
    end

    // divider chain
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        vau_div_cell #(
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_ctx    (dv_ctx[k]),
            .in_div    (dv_div[k]),
            .in_num    (dv_num[k]),
            .in_rem    (dv_rem[k]),
            .in_quo    (dv_quo[k]),
            .out_valid (dv_valid[k+1]),
            .out_ctx   (dv_ctx[k+1]),
            .out_div   (dv_div[k+1]),
            .out_num   (dv_num[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_quo   (dv_quo[k+1])
        );
    end

    // final selection for divide, normalize and length
    ctx_t      fc;
    logic      fzero;
    sat_t      qsat;
    out_item_t res_next;
    logic [W-1:0] fword [3];

    always_comb
    begin
        fc    = dv_ctx[QW];
        fzero = dv_div[QW] == '0;
        qsat  = '0;
        for (int i = 0; i < 3; i++)
        begin
            fword[i] = fc.r_word[i];
        end
        res_next            = '0;
        res_next.scalar_out = fc.so_word;
        res_next.overflow   = fc.ovf;
        unique case (fc.cmd) inside
            CMD_DIV:
            begin
                if (fzero)
                begin
                    res_next.div_zero = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (fc.a_mag[i] == '0)
                        begin
                            fword[i] = '0;
                        end
                        else
                        begin
                            fword[i] = {fc.a_neg[i], {(W-1){~fc.a_neg[i]}}};
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        qsat     = sat_word(fc.a_neg[i] ^ fc.s_neg,
                                            SAT_W'(dv_quo[QW][i]));
                        fword[i] = qsat.word;
                        res_next.overflow = res_next.overflow | qsat.ovf;
                    end
                end
            end
            CMD_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (fzero)
                    begin
                        fword[i] = fc.a_neg[i] ? (~fc.a_mag[i] + 1'b1) : fc.a_mag[i];
                    end
                    else
                    begin
                        qsat     = sat_word(fc.a_neg[i], SAT_W'(dv_quo[QW][i]));
                        fword[i] = qsat.word;
                        res_next.overflow = res_next.overflow | qsat.ovf;
                    end
                end
            end
            CMD_LEN:
            begin
                qsat                = sat_word(1'b0, SAT_W'(dv_div[QW]));
                res_next.scalar_out = qsat.word;
                res_next.overflow   = qsat.ovf;
            end
            default:
            begin
            end
        endcase
        res_next.rx = fword[0];
        res_next.ry = fword[1];
        res_next.rz = fword[2];
    end

    // output register
    logic      done_reg;
    out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `VAU_ASSERT_IMP(a_done_latency, done, $past(start, LAT),
                    "result without an item taken at the pipeline depth")
    `VAU_ASSERT_NEVER(a_dz_no_ovf, done && result.div_zero && result.overflow,
                      "divide by zero also flagged overflow")
    `VAU_ASSERT_IMP(a_scalar_no_vec, done && (result.scalar_out != '0),
                    (result.rx == '0) && (result.ry == '0) && (result.rz == '0),
                    "scalar result with a nonzero vector")

endmodule
